// ===== rtl/core/htp_pkg.sv =====
// shared types and constants for the triangular-probe hash table
package htp_pkg;

    localparam int HASH_W  = 32;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int LIMIT_W = 10;
    localparam int SLOT_W  = 5;
    localparam int CFG_W   = 10;

    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = 5'd15;
    localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RST = 10'd500;

    typedef enum logic {
        CFG_MAX_ENTRIES = 1'b0,
        CFG_PROBE_LIMIT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FAIL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        VAL_ZERO   = 2'd0,
        VAL_STORED = 2'd1,
        VAL_NEW    = 2'd2
    } t_val_sel;

    typedef enum logic [2:0] {
        S_CLEAR = 3'd0,
        S_IDLE  = 3'd1,
        S_HASH  = 3'd2,
        S_READ  = 3'd3,
        S_CHECK = 3'd4,
        S_DONE  = 3'd5
    } t_state;

    typedef struct packed {
        logic                 opcode;
        logic [KEY_W-1:0]     key;
        logic [HASH_W-1:0]    key_hash;
        logic [VALUE_W-1:0]   new_value;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   read_value;
        logic [SLOT_W-1:0]    slot_index;
        logic [COUNT_W-1:0]   entry_count;
    } t_out_item;

    // one table slot as held in memory
    typedef struct packed {
        logic                 valid;
        logic [HASH_W-1:0]    hash;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
    } t_slot;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       hash_step;
        logic       start_probe;
        logic       rd_en;
        logic       advance;
        logic       write;
        logic       insert_new;
        logic       set_result;
        t_status    status;
        t_val_sel   val_sel;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic       clear_last;
        logic       hash_done;
        logic       slot_empty;
        logic       slot_match;
        logic       limit_hit;
        logic       full;
        logic       is_lookup;
        logic       out_busy;
    } t_dp_sts;

endpackage

// ===== rtl/core/hash_table_triangular_probe.sv =====
// top level of the open-addressing hash table with triangular probing
//
//  channel   direction  handshake                payload
//  in        to block   i_in_valid / o_in_stall  i_in_item  (opcode, key, key_hash, new_value)
//  out       from block o_out_valid / i_out_stall o_out_item (status, read_value, slot_index,
//                                                              entry_count)
//  cfg       to block   i_cfg_we                 i_cfg_index, i_cfg_wdata
//
// an item is hashed, probed and its result loaded before the next one is taken: each probed
// slot costs one registered read of the slot memory and one compare
// with a table size that is not a power of two the start slot also needs
// a reciprocal multiply and then a subtract
// after reset a clearing pass empties every slot of the slot memory; no transaction
// is taken meanwhile
// the finished result sits in an output register, so the next transaction is taken while it
// is stalled
module hash_table_triangular_probe #(
    parameter int TABLE_SIZE = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  htp_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output htp_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [htp_pkg::CFG_W-1:0] i_cfg_wdata
);
    import htp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    htp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    htp_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/core/htp_ram.sv =====
// generic single-write, single-read ram with registered read data
module htp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/htp_ctrl.sv =====
// sequencing state machine for the hash table
module htp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  htp_pkg::t_dp_sts i_sts,
    output htp_pkg::t_dp_cmd o_cmd
);
    import htp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_HASH;
            end
            S_HASH: begin
                if (i_sts.hash_done) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.slot_empty || i_sts.slot_match || i_sts.limit_hit) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_HASH: begin
                o_cmd.hash_step   = !i_sts.hash_done;
                o_cmd.start_probe = i_sts.hash_done;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            S_CHECK: begin
                priority if (i_sts.slot_empty) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.val_sel    = VAL_ZERO;
                    priority if (i_sts.is_lookup) begin
                        o_cmd.status = ST_NOT_FOUND;
                    end else if (i_sts.full) begin
                        o_cmd.status = ST_FAIL;
                    end else begin
                        o_cmd.status     = ST_INSERTED;
                        o_cmd.write      = 1'b1;
                        o_cmd.insert_new = 1'b1;
                    end
                end else if (i_sts.slot_match) begin
                    o_cmd.set_result = 1'b1;
                    if (i_sts.is_lookup) begin
                        o_cmd.status  = ST_FOUND;
                        o_cmd.val_sel = VAL_STORED;
                    end else begin
                        o_cmd.status  = ST_UPDATED;
                        o_cmd.val_sel = VAL_NEW;
                        o_cmd.write   = 1'b1;
                    end
                end else begin
                    // step on; the slot just reached is reported if the limit hits
                    o_cmd.advance    = 1'b1;
                    o_cmd.set_result = i_sts.limit_hit;
                    o_cmd.status     = ST_FAIL;
                    o_cmd.val_sel    = VAL_ZERO;
                end
            end
            S_DONE: begin
                o_cmd.out_load = !i_sts.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> ($past(r_state) == S_READ))
        else $error("slot check without a preceding read");

    a_accept_starts_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_HASH))
        else $error("accepted transaction did not start hashing");
`endif

endmodule

// ===== rtl/core/htp_dp.sv =====
// datapath: item and probe registers, slot memory, config and result registers
module htp_dp #(
    parameter int TABLE_SIZE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  htp_pkg::t_dp_cmd   i_cmd,
    output htp_pkg::t_dp_sts   o_sts,
    input  htp_pkg::t_in_item  i_in_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [htp_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output htp_pkg::t_out_item o_out_item
);
    import htp_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int PW = IW + 1;
    localparam bit POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam logic [PW-1:0] TS = PW'(TABLE_SIZE);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);

    t_in_item              r_item;
    logic [COUNT_W-1:0]    r_cfg_max;
    logic [LIMIT_W-1:0]    r_cfg_limit;
    logic [COUNT_W-1:0]    r_live;
    logic [IW-1:0]         r_clr;
    logic [IW-1:0]         r_pos;
    logic [IW-1:0]         r_stride;
    logic [LIMIT_W-1:0]    r_step;
    t_status               r_res_status;
    logic [VALUE_W-1:0]    r_res_value;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [IW-1:0]         hash_rem;
    logic                  hash_done;
    logic [PW-1:0]         pos_sum;
    logic [IW-1:0]         n_pos;
    logic [IW-1:0]         n_stride;
    t_slot                 rd_slot;
    t_slot                 wr_slot;
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [VALUE_W-1:0]    n_res_value;

    // start slot: hash mod table size
    generate
        if (POW2) begin : g_mask
            assign hash_rem  = r_item.key_hash[IW-1:0];
            assign hash_done = 1'b1;
        end else begin : g_recip
            // floor(2^SH / size) underestimates the quotient by at most one
            localparam int SH  = HASH_W + IW;
            localparam int PRW = 2 * HASH_W + 1;
            localparam logic [HASH_W:0] RECIP = (HASH_W + 1)'((65'(1) << SH) / TABLE_SIZE);
            logic [1:0]        r_cnt;
            logic [PRW-1:0]    r_prod;
            logic [PW-1:0]     r_diff;
            logic [HASH_W-1:0] quot;

            assign quot = HASH_W'(r_prod >> SH);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= '0;
                end else if (i_cmd.load) begin
                    r_cnt <= 2'd2;
                end else if (i_cmd.hash_step) begin
                    r_cnt <= r_cnt - 2'd1;
                end
            end

            // product first, then a remainder estimate below twice the table size
            always_ff @(posedge i_clk) begin
                if (i_cmd.hash_step) begin
                    r_prod <= PRW'(r_item.key_hash) * PRW'(RECIP);
                    r_diff <= PW'(r_item.key_hash - HASH_W'(quot * HASH_W'(TABLE_SIZE)));
                end
            end

            assign hash_rem  = (r_diff >= TS) ? IW'(r_diff - TS) : r_diff[IW-1:0];
            assign hash_done = (r_cnt == '0);
        end
    endgenerate

    // triangular step: both terms stay below the table size
    assign pos_sum  = {1'b0, r_pos} + {1'b0, r_stride};
    assign n_pos    = (pos_sum >= TS) ? IW'(pos_sum - TS) : pos_sum[IW-1:0];
    assign n_stride = (r_stride == LAST_SLOT) ? '0 : r_stride + IW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_max   <= MAX_ENTRIES_RST;
            r_cfg_limit <= PROBE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MAX_ENTRIES: r_cfg_max   <= i_cfg_wdata[COUNT_W-1:0];
                CFG_PROBE_LIMIT: r_cfg_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default:         r_cfg_max   <= r_cfg_max;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write && i_cmd.insert_new) begin
                r_live <= r_live + COUNT_W'(1);
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.start_probe) begin
            r_pos    <= hash_rem;
            r_stride <= IW'(1);
            r_step   <= LIMIT_W'(1);
        end else if (i_cmd.advance) begin
            r_pos    <= n_pos;
            r_stride <= n_stride;
            r_step   <= r_step + LIMIT_W'(1);
        end
        if (i_cmd.set_result) begin
            r_res_status <= i_cmd.status;
            r_res_value  <= n_res_value;
        end
        if (i_cmd.out_load) begin
            r_out.status      <= r_res_status;
            r_out.read_value  <= r_res_value;
            r_out.slot_index  <= SLOT_W'(r_pos);
            r_out.entry_count <= r_live;
        end
    end

    always_comb begin
        unique case (i_cmd.val_sel)
            VAL_ZERO:   n_res_value = '0;
            VAL_STORED: n_res_value = rd_slot.value;
            VAL_NEW:    n_res_value = r_item.new_value;
            default:    n_res_value = '0;
        endcase
    end

    // clearing pass writes an empty slot at each address
    assign wr_slot   = i_cmd.clear ? '0 :
                       {1'b1, r_item.key_hash, r_item.key, r_item.new_value};
    assign ram_we    = i_cmd.clear || i_cmd.write;
    assign ram_waddr = i_cmd.clear ? r_clr : r_pos;

    htp_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_slot),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_pos),
        .o_rdata (rd_slot)
    );

    always_comb begin
        o_sts            = '0;
        o_sts.clear_last = (r_clr == LAST_SLOT);
        o_sts.hash_done  = hash_done;
        o_sts.slot_empty = !rd_slot.valid;
        o_sts.slot_match = rd_slot.valid && (rd_slot.hash == r_item.key_hash)
                           && (rd_slot.key == r_item.key);
        o_sts.limit_hit  = ({1'b0, r_step} + (LIMIT_W + 1)'(1)) >= {1'b0, r_cfg_limit};
        o_sts.full       = (r_live >= r_cfg_max);
        o_sts.is_lookup  = (t_opcode'(r_item.opcode) == OP_LOOKUP);
        o_sts.out_busy   = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (({1'b0, r_pos} < TS) && ({1'b0, r_stride} < TS)))
        else $error("probe position or stride outside the table");

    a_no_overwrite_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over one still waiting");
`endif

endmodule

// ===== test/tb_hash_table_triangular_probe.sv =====
// testbench for the triangular-probe hash table: directed table, random phases, predictor check
`timescale 1ns / 100ps

module tb_hash_table_triangular_probe;
    import htp_pkg::*;

    localparam int TABLE_SLOTS  = 32;
    localparam int POOL_SIZE    = 40;
    localparam int NUM_PHASES   = 5;
    localparam int IDLE_LIMIT   = 5000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 80;

    localparam int PHASE_MAX   [NUM_PHASES] = '{8, 20, 0, 31, 31};
    localparam int PHASE_LIMIT [NUM_PHASES] = '{500, 4, 0, 1023, 12};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{220, 200, 160, 220, 200};

    typedef struct {
        bit                 is_cfg;
        t_cfg_index         cfg_idx;
        logic [CFG_W-1:0]   cfg_data;
        t_in_item           item;
        bit                 known;
        t_out_item          exp;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out_item;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_wdata;

    // shadow of the table contents and registers
    bit                 tbl_valid [TABLE_SLOTS];
    logic [HASH_W-1:0]  tbl_hash  [TABLE_SLOTS];
    logic [KEY_W-1:0]   tbl_key   [TABLE_SLOTS];
    logic [VALUE_W-1:0] tbl_value [TABLE_SLOTS];
    logic [COUNT_W-1:0] tbl_count;
    logic [COUNT_W-1:0] cfg_max_entries;
    logic [LIMIT_W-1:0] cfg_probe_limit;

    t_out_item          pending_results [$];
    t_stim_row          typed_hints [$];
    t_stim_row          directed_rows [$];
    logic [KEY_W-1:0]   pool_key  [POOL_SIZE];
    logic [HASH_W-1:0]  pool_hash [POOL_SIZE];

    int                 mismatch_count = 0;
    int                 results_seen = 0;
    int                 idle_cycles = 0;
    bit                 hold_off_req = 0;
    bit                 tx_calm = 0;

    hash_table_triangular_probe dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // probe the shadow table and apply the transaction to it
    function automatic t_out_item table_access(t_in_item it);
        int unsigned pos;
        int unsigned step;
        bit          hit;
        bit          empty;
        bit          limit;
        t_out_item   r;
        pos   = it.key_hash % TABLE_SLOTS;
        step  = 1;
        hit   = 0;
        empty = 0;
        limit = 0;
        while (!hit && !empty && !limit) begin
            if (!tbl_valid[pos]) begin
                empty = 1;
            end else if (tbl_hash[pos] == it.key_hash && tbl_key[pos] == it.key) begin
                hit = 1;
            end else begin
                pos  = (pos + step) % TABLE_SLOTS;
                step = step + 1;
                if (step >= int'(cfg_probe_limit)) begin
                    limit = 1;
                end
            end
        end
        r.read_value = '0;
        r.slot_index = pos[SLOT_W-1:0];
        if (limit) begin
            r.status = ST_FAIL;
        end else if (it.opcode == OP_LOOKUP) begin
            if (hit) begin
                r.status     = ST_FOUND;
                r.read_value = tbl_value[pos];
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end else if (hit) begin
            tbl_value[pos] = it.new_value;
            r.status       = ST_UPDATED;
            r.read_value   = it.new_value;
        end else if (tbl_count >= cfg_max_entries) begin
            r.status = ST_FAIL;
        end else begin
            tbl_valid[pos] = 1;
            tbl_hash[pos]  = it.key_hash;
            tbl_key[pos]   = it.key;
            tbl_value[pos] = it.new_value;
            tbl_count      = tbl_count + 1'b1;
            r.status       = ST_INSERTED;
        end
        r.entry_count = tbl_count;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // check results, then predict accepted transactions
    always @(posedge i_clk) begin
        t_out_item want;
        t_stim_row hint;
        if (!i_rst_n) begin
            foreach (tbl_valid[i]) tbl_valid[i] = 0;
            tbl_count       = '0;
            cfg_max_entries = MAX_ENTRIES_RST;
            cfg_probe_limit = PROBE_LIMIT_RST;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with none expected", 32'(o_out_item.status), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.status !== want.status)
                        flag_mismatch("status", 32'(o_out_item.status), 32'(want.status));
                    if (o_out_item.read_value !== want.read_value)
                        flag_mismatch("read_value", o_out_item.read_value, want.read_value);
                    if (o_out_item.slot_index !== want.slot_index)
                        flag_mismatch("slot_index", 32'(o_out_item.slot_index),
                                      32'(want.slot_index));
                    if (o_out_item.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", 32'(o_out_item.entry_count),
                                      32'(want.entry_count));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_ENTRIES)
                    cfg_max_entries = i_cfg_wdata[COUNT_W-1:0];
                else
                    cfg_probe_limit = i_cfg_wdata[LIMIT_W-1:0];
            end
            if (i_in_valid && !o_in_stall) begin
                want = table_access(i_in_item);
                hint = typed_hints.pop_front();
                pending_results.push_back(hint.known ? hint.exp : want);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("[hash_table_triangular_probe] ERROR");
            $finish;
        end
    end

    // result side: random stall per transaction, calm stretches, one long hold-off on request
    initial begin
        int hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 0;
                hold = LONG_HOLD;
            end else if ((results_seen / 50) % 3 == 0) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 16);
            end
            if (hold != 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            results_seen++;
        end
    end

    task automatic drive_item(t_stim_row row);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        typed_hints.push_back(row);
        i_in_item  = row.item;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // registers only change once the table has gone quiet
    task automatic write_reg(t_cfg_index idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic void add_item(t_opcode op, logic [31:0] k, logic [31:0] h,
                                     logic [31:0] v);
        t_stim_row row;
        row.is_cfg         = 0;
        row.cfg_idx        = CFG_MAX_ENTRIES;
        row.cfg_data       = '0;
        row.item.opcode    = op;
        row.item.key       = k;
        row.item.key_hash  = h;
        row.item.new_value = v;
        row.known          = 0;
        row.exp            = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_known(t_opcode op, logic [31:0] k, logic [31:0] h,
                                      logic [31:0] v, t_status st, logic [31:0] rd,
                                      logic [SLOT_W-1:0] slot, logic [COUNT_W-1:0] cnt);
        t_stim_row row;
        add_item(op, k, h, v);
        row = directed_rows.pop_back();
        row.known           = 1;
        row.exp.status      = st;
        row.exp.read_value  = rd;
        row.exp.slot_index  = slot;
        row.exp.entry_count = cnt;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(t_cfg_index idx, logic [CFG_W-1:0] data);
        t_stim_row row;
        row.is_cfg   = 1;
        row.cfg_idx  = idx;
        row.cfg_data = data;
        row.item     = '0;
        row.known    = 0;
        row.exp      = '0;
        directed_rows.push_back(row);
    endfunction

    // mostly keys from a small pool so that updates and hits are common
    function automatic t_stim_row random_row();
        int        sel;
        int        p;
        t_stim_row row;
        row.is_cfg   = 0;
        row.cfg_idx  = CFG_MAX_ENTRIES;
        row.cfg_data = '0;
        row.known    = 0;
        row.exp      = '0;
        sel    = $urandom_range(0, 99);
        p      = $urandom_range(0, POOL_SIZE - 1);
        row.item.opcode    = ($urandom_range(0, 1) == 1) ? OP_LOOKUP : OP_INSERT;
        row.item.key       = pool_key[p];
        row.item.key_hash  = pool_hash[p];
        row.item.new_value = $urandom;
        if (sel < 8) begin
            row.item.key      = $urandom;
            row.item.key_hash = $urandom;
        end else if (sel < 14) begin
            // right key under another entry's hash
            row.item.key_hash = pool_hash[$urandom_range(0, POOL_SIZE - 1)];
        end
        return row;
    endfunction

    initial begin
        logic [CFG_W-1:0] data;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MAX_ENTRIES;
        i_cfg_wdata = '0;

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_key[i]  = $urandom;
            pool_hash[i] = $urandom;
            if (i < 16) pool_hash[i][4:0] = 5'($urandom_range(0, 3));
        end

        // empty table, extremes, collisions, then full and probe limit cases
        add_known(OP_LOOKUP, 32'h0, 32'h0, 32'h0, ST_NOT_FOUND, 32'h0, 5'd0, 5'd0);
        add_known(OP_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF, ST_INSERTED, 32'h0, 5'd0, 5'd1);
        add_known(OP_LOOKUP, 32'h0, 32'h0, 32'h0, ST_FOUND, 32'hFFFF_FFFF, 5'd0, 5'd1);
        add_known(OP_INSERT, 32'h0, 32'h0, 32'h0, ST_UPDATED, 32'h0, 5'd0, 5'd1);
        add_known(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
                  ST_INSERTED, 32'h0, 5'd31, 5'd2);
        add_known(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                  ST_FOUND, 32'hA5A5_A5A5, 5'd31, 5'd2);
        add_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h5A5A_5A5A);
        add_item(OP_INSERT, 32'h0, 32'h20, 32'h1234_5678);
        add_item(OP_LOOKUP, 32'h0, 32'h20, 32'h0);
        add_item(OP_LOOKUP, 32'h1, 32'h0, 32'h0);
        add_item(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFE1, 32'hDEAD_BEEF);
        add_item(OP_LOOKUP, 32'h8000_0000, 32'h7FFF_FFE1, 32'h5555_5555);
        add_cfg(CFG_MAX_ENTRIES, 10'd5);
        add_known(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1, ST_FAIL, 32'h0, 5'd21, 5'd5);
        add_known(OP_INSERT, 32'h0, 32'h0, 32'h0F0F_0F0F,
                  ST_UPDATED, 32'h0F0F_0F0F, 5'd0, 5'd5);
        add_cfg(CFG_PROBE_LIMIT, 10'd1);
        add_known(OP_LOOKUP, 32'h7, 32'h0, 32'h0, ST_FAIL, 32'h0, 5'd1, 5'd5);
        add_known(OP_LOOKUP, 32'h0, 32'h0, 32'h0, ST_FOUND, 32'h0F0F_0F0F, 5'd0, 5'd5);
        add_cfg(CFG_PROBE_LIMIT, 10'd3);
        add_item(OP_LOOKUP, 32'h7, 32'h0, 32'h0);
        add_cfg(CFG_MAX_ENTRIES, 10'd0);
        add_cfg(CFG_PROBE_LIMIT, 10'd0);
        add_known(OP_INSERT, 32'h9, 32'h9, 32'h1, ST_FAIL, 32'h0, 5'd9, 5'd5);
        add_item(OP_LOOKUP, 32'h7, 32'h0, 32'h0);
        add_cfg(CFG_MAX_ENTRIES, 10'h3FF);
        add_cfg(CFG_PROBE_LIMIT, 10'h3FF);
        add_item(OP_INSERT, 32'h9, 32'h9, 32'h1);

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_data);
            else
                drive_item(directed_rows[i]);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // upper bits of the entry limit write are don't-care
            data = CFG_W'(($urandom_range(0, 31) << COUNT_W) | PHASE_MAX[ph]);
            write_reg(CFG_MAX_ENTRIES, data);
            write_reg(CFG_PROBE_LIMIT, CFG_W'(PHASE_LIMIT[ph]));
            if (ph == 0 || ph == 3) hold_off_req = 1;
            for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
                // back-to-back at phase start so the hold-off fills the block
                tx_calm = (n < 30) || ((n / 40) % 3 == 1);
                drive_item(random_row());
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[hash_table_triangular_probe] OK");
        end else begin
            $display("[hash_table_triangular_probe] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/htp_pkg.sv
rtl/core/htp_ram.sv
rtl/core/htp_ctrl.sv
rtl/core/htp_dp.sv
rtl/core/hash_table_triangular_probe.sv
test/tb_hash_table_triangular_probe.sv
